### design/obb_pkg.sv
// Shared constants and types for the oriented rectangle overlap test.
package obb_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int AXIS_FRAC_BITS_DEF = 14;

  localparam int CENTER_W = 24;
  localparam int HALF_W   = 20;
  localparam int NORMAL_W = 16;

  // stages inside the sine/cosine unit
  localparam int SC_STAGES = 4;

  // quarter-wave sine polynomial coefficients, Q.30
  localparam logic [30:0] POLY_A = 31'd1686629713;
  localparam logic [30:0] POLY_B = 31'd688904866;
  localparam logic [30:0] POLY_C = 31'd76016977;

  typedef struct packed {
    logic [SC_STAGES-1:0] load;
  } sc_ctl_t;

endpackage

### design/obb_overlap_test.sv
// Top level: pipelined separating axis overlap test for two oriented rectangles.
//
// One rectangle pair is taken per clock cycle while req_ready is high, and its
// result passes through the ten register stages of the pipeline: four for the
// polynomial sine/cosine chain (one multiply per stage), one for the rotated
// half-size products, one for the rounded corners, one for the corner-onto-axis
// dot products, one for the interval bounds, one for the gap and overlap test and
// one for the least-overlap selection. A full stage holds its item while the next
// stage cannot advance, so a stalled result output backs the pipe up one stage at
// a time and bubbles close up; req_ready drops only when every stage is full.
// Opposite edge normals give mirrored intervals with the same gap and overlap, so
// only the two distinct axes of each rectangle are evaluated; a tie keeps the
// earlier axis. Separated pairs report hit = 0 with a zero normal.
module obb_overlap_test #(
  parameter int ANGLE_BITS     = obb_pkg::ANGLE_BITS_DEF,
  parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  logic signed [obb_pkg::CENTER_W-1:0] a_center_x,
  input  logic signed [obb_pkg::CENTER_W-1:0] a_center_y,
  input  logic [obb_pkg::HALF_W-1:0]          a_half_width,
  input  logic [obb_pkg::HALF_W-1:0]          a_half_height,
  input  logic [ANGLE_BITS-1:0]               a_angle,
  input  logic signed [obb_pkg::CENTER_W-1:0] b_center_x,
  input  logic signed [obb_pkg::CENTER_W-1:0] b_center_y,
  input  logic [obb_pkg::HALF_W-1:0]          b_half_width,
  input  logic [obb_pkg::HALF_W-1:0]          b_half_height,
  input  logic [ANGLE_BITS-1:0]               b_angle,
  output logic rsp_valid,
  input  logic rsp_ready,
  output logic hit,
  output logic signed [obb_pkg::NORMAL_W-1:0] normal_x,
  output logic signed [obb_pkg::NORMAL_W-1:0] normal_y
);
  import obb_pkg::*;

  localparam int NST = 10;
  localparam int SW  = AXIS_FRAC_BITS + 2;          // sine/cosine and axis
  localparam int PW  = SW + HALF_W + 1;             // half size times trig
  localparam int OW  = PW + 2 - AXIS_FRAC_BITS;     // rounded corner offset
  localparam int CW  = ((OW > CENTER_W) ? OW : CENTER_W) + 1;
  localparam int DW  = CW + SW + 1;                 // dot product
  localparam int VW  = DW + 1;                      // overlap
  localparam logic signed [PW+1:0] RBIAS = (PW+2)'(1) << (AXIS_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [HALF_W-1:0]          hw;
    logic [HALF_W-1:0]          hh;
  } rect_t;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
  } axis_t;

  // stage valid bits and per-stage advance
  logic [NST:1] v;
  logic [NST:1] move;

  assign move[NST] = !v[NST] || rsp_ready;
  for (genvar k = 1; k < NST; k++) begin : g_move
    assign move[k] = !v[k] || move[k+1];
  end

  assign req_ready = move[1];
  assign rsp_valid = v[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (move[1]) v[1] <= req_valid;
      for (int k = 2; k <= NST; k++) begin
        if (move[k]) v[k] <= v[k-1];
      end
    end
  end

  // stages 1..4: sine/cosine of both angles
  sc_ctl_t sc_ctl;
  logic signed [SW-1:0] sin_a, cos_a, sin_b, cos_b;

  assign sc_ctl.load = move[SC_STAGES:1];

  obb_sincos #(.ANGLE_BITS(ANGLE_BITS), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_sc_a (
    .clk(clk), .ctl(sc_ctl), .ang(a_angle), .sin_val(sin_a), .cos_val(cos_a)
  );

  obb_sincos #(.ANGLE_BITS(ANGLE_BITS), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_sc_b (
    .clk(clk), .ctl(sc_ctl), .ang(b_angle), .sin_val(sin_b), .cos_val(cos_b)
  );

  // rectangle geometry rides along stages 1..5
  rect_t geo [1:5][2];

  always_ff @(posedge clk) begin
    if (move[1]) begin
      geo[1][0] <= '{cx: a_center_x, cy: a_center_y, hw: a_half_width, hh: a_half_height};
      geo[1][1] <= '{cx: b_center_x, cy: b_center_y, hw: b_half_width, hh: b_half_height};
    end
    for (int k = 2; k <= 5; k++) begin
      if (move[k]) geo[k] <= geo[k-1];
    end
  end

  // stage 5: half size times sine/cosine
  logic signed [SW-1:0] s4 [2], c4 [2];
  logic signed [SW-1:0] s5 [2], c5 [2];
  logic signed [PW-1:0] pp5 [2], qq5 [2], rr5 [2], tt5 [2];

  assign s4[0] = sin_a;
  assign c4[0] = cos_a;
  assign s4[1] = sin_b;
  assign c4[1] = cos_b;

  always_ff @(posedge clk) begin
    if (move[5]) begin
      for (int r = 0; r < 2; r++) begin
        s5[r]  <= s4[r];
        c5[r]  <= c4[r];
        pp5[r] <= PW'($signed({1'b0, geo[4][r].hw})) * PW'(c4[r]);
        qq5[r] <= PW'($signed({1'b0, geo[4][r].hh})) * PW'(s4[r]);
        rr5[r] <= PW'($signed({1'b0, geo[4][r].hw})) * PW'(s4[r]);
        tt5[r] <= PW'($signed({1'b0, geo[4][r].hh})) * PW'(c4[r]);
      end
    end
  end

  // stage 6: corners rounded half up to the coordinate grid; axes formed
  logic signed [PW+1:0] ox [2][4], oy [2][4];
  logic signed [CW-1:0] px6 [2][4], py6 [2][4];
  axis_t                ax6 [4];

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 4; i++) begin
        // corner order: (-,-) (+,-) (+,+) (-,+)
        ox[r][i] = ((i == 0 || i == 3) ? -(PW+2)'(pp5[r]) : (PW+2)'(pp5[r]))
                 - ((i < 2) ? -(PW+2)'(qq5[r]) : (PW+2)'(qq5[r])) + RBIAS;
        oy[r][i] = ((i == 0 || i == 3) ? -(PW+2)'(rr5[r]) : (PW+2)'(rr5[r]))
                 + ((i < 2) ? -(PW+2)'(tt5[r]) : (PW+2)'(tt5[r])) + RBIAS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move[6]) begin
      for (int r = 0; r < 2; r++) begin
        for (int i = 0; i < 4; i++) begin
          px6[r][i] <= CW'(geo[5][r].cx) + CW'($signed(ox[r][i][PW+1:AXIS_FRAC_BITS]));
          py6[r][i] <= CW'(geo[5][r].cy) + CW'($signed(oy[r][i][PW+1:AXIS_FRAC_BITS]));
        end
        ax6[2*r]   <= '{x: -s5[r], y: c5[r]};
        ax6[2*r+1] <= '{x: -c5[r], y: -s5[r]};
      end
    end
  end

  // stage 7: every corner of both rectangles onto each axis
  logic signed [DW-1:0] d7 [4][2][4];
  axis_t                ax7 [4];

  always_ff @(posedge clk) begin
    if (move[7]) begin
      ax7 <= ax6;
      for (int a = 0; a < 4; a++) begin
        for (int r = 0; r < 2; r++) begin
          for (int i = 0; i < 4; i++) begin
            d7[a][r][i] <= DW'(px6[r][i]) * DW'(ax6[a].x) + DW'(py6[r][i]) * DW'(ax6[a].y);
          end
        end
      end
    end
  end

  // stage 8: projected intervals
  logic signed [DW-1:0] lo_c [4][2], hi_c [4][2];
  logic signed [DW-1:0] lo8 [4][2], hi8 [4][2];
  axis_t                ax8 [4];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int r = 0; r < 2; r++) begin
        lo_c[a][r] = d7[a][r][0];
        hi_c[a][r] = d7[a][r][0];
        for (int i = 1; i < 4; i++) begin
          if (d7[a][r][i] < lo_c[a][r]) lo_c[a][r] = d7[a][r][i];
          if (d7[a][r][i] > hi_c[a][r]) hi_c[a][r] = d7[a][r][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move[8]) begin
      ax8 <= ax7;
      lo8 <= lo_c;
      hi8 <= hi_c;
    end
  end

  // stage 9: gap test and overlap per axis
  logic [3:0]           sep9;
  logic signed [VW-1:0] ov9 [4];
  axis_t                ax9 [4];

  always_ff @(posedge clk) begin
    if (move[9]) begin
      ax9 <= ax8;
      for (int a = 0; a < 4; a++) begin
        sep9[a] <= (lo8[a][1] > hi8[a][0]) || (hi8[a][1] < lo8[a][0]);
        ov9[a]  <= VW'((hi8[a][0] < hi8[a][1]) ? hi8[a][0] : hi8[a][1])
                 - VW'((lo8[a][0] > lo8[a][1]) ? lo8[a][0] : lo8[a][1]);
      end
    end
  end

  // stage 10: least overlap, earlier axis wins ties
  logic [1:0]           best_idx;
  logic signed [VW-1:0] best_ov;
  logic signed [31:0]   nx_ext, ny_ext;

  always_comb begin
    best_idx = 2'd0;
    best_ov  = ov9[0];
    for (int a = 1; a < 4; a++) begin
      if (ov9[a] < best_ov) begin
        best_ov  = ov9[a];
        best_idx = 2'(a);
      end
    end
    nx_ext = 32'(ax9[best_idx].x);
    ny_ext = 32'(ax9[best_idx].y);
  end

  always_ff @(posedge clk) begin
    if (move[NST]) begin
      hit      <= ~|sep9;
      normal_x <= (|sep9) ? '0 : $signed(nx_ext[NORMAL_W-1:0]);
      normal_y <= (|sep9) ? '0 : $signed(ny_ext[NORMAL_W-1:0]);
    end
  end

`ifndef ASSERT_OFF
  a_miss_zero_normal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> normal_x == '0 && normal_y == '0)
    else $error("separated pair reports a nonzero normal");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (&v))
    else $error("input stalled while a pipeline stage is empty");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    v[NST] && !rsp_ready |=> v[NST] && $stable(hit) && $stable(normal_x)
      && $stable(normal_y))
    else $error("stalled result dropped or changed");
`endif

endmodule

### design/obb_sincos.sv
// Four-stage pipelined fixed-point sine and cosine of one binary angle.
module obb_sincos #(
  parameter int ANGLE_BITS     = obb_pkg::ANGLE_BITS_DEF,
  parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  obb_pkg::sc_ctl_t              ctl,
  input  logic [ANGLE_BITS-1:0]         ang,
  output logic signed [AXIS_FRAC_BITS+1:0] sin_val,
  output logic signed [AXIS_FRAC_BITS+1:0] cos_val
);
  import obb_pkg::*;

  localparam int SW   = AXIS_FRAC_BITS + 2;
  localparam int ZPAD = 32 - ANGLE_BITS;
  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
  localparam logic [31:0] RBIAS = 32'(1) << (29 - AXIS_FRAC_BITS);

  // lane 0 is sine, lane 1 cosine (quadrant advanced by one)
  logic [1:0]            quad [2];
  logic [ANGLE_BITS-2:0] arg  [2];
  logic [30:0]           z0   [2];
  logic [61:0]           pm1  [2];
  logic [61:0]           pm2  [2];
  logic [61:0]           pm3  [2];
  logic [61:0]           pm4  [2];
  logic [31:0]           rsum [2];
  logic [31:0]           mag  [2];
  logic signed [SW-1:0]  val  [2];

  logic [30:0] z1 [2], z2a [2], zb [2], z3 [2];
  logic [30:0] z2b [2], t1 [2], t2 [2];
  logic        neg1 [2], neg2 [2], neg3 [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quad[l] = ang[ANGLE_BITS-1:ANGLE_BITS-2] + 2'(l);
      arg[l]  = quad[l][0] ? (QUARTER - {1'b0, ang[ANGLE_BITS-3:0]})
                           : {1'b0, ang[ANGLE_BITS-3:0]};
      z0[l]   = {arg[l], {ZPAD{1'b0}}};
      pm1[l]  = 62'(z0[l]) * 62'(z0[l]);
      pm2[l]  = 62'(z2a[l]) * 62'(POLY_C);
      pm3[l]  = 62'(z2b[l]) * 62'(t1[l]);
      pm4[l]  = 62'(z3[l]) * 62'(t2[l]);
      rsum[l] = {1'b0, pm4[l][60:30]} + RBIAS;
      mag[l]  = rsum[l] >> (30 - AXIS_FRAC_BITS);
      val[l]  = neg3[l] ? -$signed(mag[l][SW-1:0]) : $signed(mag[l][SW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (ctl.load[0]) begin
        z1[l]   <= z0[l];
        z2a[l]  <= pm1[l][60:30];
        neg1[l] <= quad[l][1];
      end
      if (ctl.load[1]) begin
        zb[l]   <= z1[l];
        z2b[l]  <= z2a[l];
        t1[l]   <= POLY_B - {3'b000, pm2[l][57:30]};
        neg2[l] <= neg1[l];
      end
      if (ctl.load[2]) begin
        z3[l]   <= zb[l];
        t2[l]   <= POLY_A - pm3[l][60:30];
        neg3[l] <= neg2[l];
      end
    end
    if (ctl.load[3]) begin
      sin_val <= val[0];
      cos_val <= val[1];
    end
  end

endmodule
